/* sv/assert_macros.svh */
// Assertion macros shared by the ARP cache RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ARPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc assertion failed");

`endif

/* sv/arpc_pkg.sv */
// Types and constants of the ARP cache: payload words, search token, fill port.
// No dependencies; imported by arpc_cell, arp_cache_learn_and_reply and the testbench.
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam logic [10:0] MIN_FRAME_LEN  = 11'd42;
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_FRAME  = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic [15:0] arp_opcode;
    logic [31:0] target_addr;
    logic [10:0] frame_len;
  } arpc_in_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] hit_hw_addr;
    logic        send_reply;
    logic [47:0] reply_hw_addr;
    logic [31:0] reply_ip;
    logic        frame_dropped;
  } arpc_out_t;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic        active;
    logic        learn;
    logic [31:0] ip;
    logic [47:0] hw;
    logic        found;
    logic [47:0] found_hw;
    logic        free_found;
  } arpc_tok_t;

  // Fill port driven by the controller when a learned pair has no entry yet.
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] hw;
  } arpc_wr_t;

endpackage

/* sv/arp_cache_learn_and_reply.sv */
// Top level of the ARP cache: controller FSM, config register, chain of cells.
// Depends on arpc_pkg, arpc_cell and assert_macros.svh.
//
//   port group   dir   handshake           word
//   in_*         in    in_valid/in_stall   arpc_in_t request
//   out_*        out   out_valid/out_stall arpc_out_t result
//   cfg_*        in    cfg_wr_en           local IPv4 address, 32 bits
//
// Lookup, add and accepted frames raise out_valid once the search token has walked
// the cell chain, one entry per cycle, and the controller has registered the result.
// Short frames and unknown request types raise out_valid at the accepting edge.
// One request is in flight at a time; in_stall is high until its result is taken,
// so the block takes no new word before the previous result has been taken.
// Reset (synchronous, rst_n low) empties the table and clears local IP to 0.
// A stalled result holds in the output register until out_stall drops.
`include "assert_macros.svh"

module arp_cache_learn_and_reply import arpc_pkg::*; #(
  parameter int TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  arpc_in_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output arpc_out_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  state_t          state_r, state_nxt;
  logic [31:0]     local_ip_r, local_ip_nxt;
  logic            is_lookup_r, is_lookup_nxt;
  logic            reply_r, reply_nxt;
  logic            out_valid_r, out_valid_nxt;
  arpc_out_t       out_word_r, out_word_nxt;

  arpc_tok_t       tok_c  [TableEntries+1];
  logic [IdxW-1:0] fidx_c [TableEntries+1];
  arpc_tok_t       tok_head;
  arpc_wr_t        wr;
  logic [IdxW-1:0] wr_idx;

  assign tok_c[0]  = tok_head;
  assign fidx_c[0] = '0;

  // chain of entries; token enters at cell 0 and leaves after the last one
  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    arpc_cell #(
      .TableEntries (TableEntries),
      .Idx          (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok_c[k]),
      .fidx_i   (fidx_c[k]),
      .wr_i     (wr),
      .wr_idx_i (wr_idx),
      .tok_o    (tok_c[k+1]),
      .fidx_o   (fidx_c[k+1])
    );
  end

  assign local_ip_nxt = cfg_wr_en ? cfg_wr_data : local_ip_r;

  always_comb begin
    state_nxt     = state_r;
    is_lookup_nxt = is_lookup_r;
    reply_nxt     = reply_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    in_stall      = (state_r != S_IDLE);
    tok_head      = '0;
    wr            = '0;
    wr_idx        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tok_head.ip   = in_word.ip_addr;
          tok_head.hw   = in_word.hw_addr;
          is_lookup_nxt = 1'b0;
          reply_nxt     = 1'b0;
          case (in_word.req_type)
            REQ_LOOKUP: begin
              tok_head.active = 1'b1;
              is_lookup_nxt   = 1'b1;
              state_nxt       = S_SCAN;
            end
            REQ_ADD: begin
              tok_head.active = 1'b1;
              tok_head.learn  = 1'b1;
              state_nxt       = S_SCAN;
            end
            REQ_FRAME: begin
              if (in_word.frame_len < MIN_FRAME_LEN) begin
                // drop a short frame: learn nothing
                out_word_nxt               = '0;
                out_word_nxt.frame_dropped = 1'b1;
                out_valid_nxt              = 1'b1;
                state_nxt                  = S_OUT;
              end else begin
                tok_head.active = 1'b1;
                tok_head.learn  = 1'b1;
                reply_nxt       = (in_word.arp_opcode == OPCODE_REQUEST) &&
                                  (in_word.target_addr == local_ip_r);
                state_nxt       = S_SCAN;
              end
            end
            default: begin
              out_word_nxt  = '0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_c[TableEntries].active) begin
          if (tok_c[TableEntries].learn && !tok_c[TableEntries].found) begin
            // no entry holds this IP: fill lowest free one, else overwrite entry 0
            wr.en  = 1'b1;
            wr.ip  = tok_c[TableEntries].ip;
            wr.hw  = tok_c[TableEntries].hw;
            wr_idx = tok_c[TableEntries].free_found ? fidx_c[TableEntries] : '0;
          end
          out_word_nxt     = '0;
          if (is_lookup_r && tok_c[TableEntries].found) begin
            out_word_nxt.hit         = 1'b1;
            out_word_nxt.hit_hw_addr = tok_c[TableEntries].found_hw;
          end
          if (reply_r) begin
            out_word_nxt.send_reply    = 1'b1;
            out_word_nxt.reply_hw_addr = tok_c[TableEntries].hw;
            out_word_nxt.reply_ip      = tok_c[TableEntries].ip;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      local_ip_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      local_ip_r  <= local_ip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_lookup_r <= is_lookup_nxt;
    reply_r     <= reply_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ARPC_ASSERT_IMPL(a_tok_exits_in_scan, clk, rst_n, tok_c[TableEntries].active, state_r == S_SCAN)
  `ARPC_ASSERT_IMPL(a_out_only_in_out, clk, rst_n, out_valid_r, state_r == S_OUT)
  `ARPC_ASSERT_IMPL(a_fill_on_miss, clk, rst_n, wr.en, tok_c[TableEntries].learn && !tok_c[TableEntries].found)
  `ARPC_ASSERT_NEXT(a_scan_end_gives_word, clk, rst_n, (state_r == S_SCAN) && tok_c[TableEntries].active, out_valid_r)
  `ARPC_ASSERT_IMPL(a_one_result_kind, clk, rst_n, out_valid_r && out_word_r.hit, !out_word_r.send_reply && !out_word_r.frame_dropped)

endmodule

/* sv/arpc_cell.sv */
// One entry of the ARP cache chain: stores a pair, checks the passing token.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_cell import arpc_pkg::*; #(
  parameter int TableEntries = TABLE_ENTRIES_DEF,
  parameter int Idx          = 0,
  localparam int IdxW        = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  arpc_tok_t        tok_i,
  input  logic [IdxW-1:0]  fidx_i,
  input  arpc_wr_t         wr_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  output arpc_tok_t        tok_o,
  output logic [IdxW-1:0]  fidx_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic            valid_r, valid_nxt;
  logic [31:0]     ip_r, ip_nxt;
  logic [47:0]     hw_r, hw_nxt;
  arpc_tok_t       tok_r, tok_nxt;
  logic [IdxW-1:0] fidx_r, fidx_nxt;
  logic            hit_here, free_here, fill_here;

  always_comb begin
    hit_here  = tok_i.active && !tok_i.found && valid_r && (ip_r == tok_i.ip);
    free_here = tok_i.active && !tok_i.free_found && !valid_r;
    fill_here = wr_i.en && (wr_idx_i == MyIdx);

    tok_nxt  = tok_i;
    fidx_nxt = fidx_i;
    if (hit_here) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.found_hw = hw_r;
    end
    if (free_here) begin
      tok_nxt.free_found = 1'b1;
      fidx_nxt           = MyIdx;
    end

    valid_nxt = valid_r;
    ip_nxt    = ip_r;
    hw_nxt    = hw_r;
    if (fill_here) begin
      valid_nxt = 1'b1;
      ip_nxt    = wr_i.ip;
      hw_nxt    = wr_i.hw;
    end else if (hit_here && tok_i.learn) begin
      // refresh the hardware address of a known IP
      hw_nxt = tok_i.hw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r   <= ip_nxt;
    hw_r   <= hw_nxt;
    fidx_r <= fidx_nxt;
  end

  assign tok_o  = tok_r;
  assign fidx_o = fidx_r;

  // an entry once filled stays valid until reset
  `ARPC_ASSERT_NEXT(a_valid_sticks, clk, rst_n, valid_r, valid_r)

endmodule

/* sim/arp_cache_learn_and_reply_tb.sv */
`timescale 1ns / 100ps
// Testbench for arp_cache_learn_and_reply: directed and random requests checked against
// a behavioral ARP table, with bursty input words and a stalling receiver.
// Depends on arpc_pkg and the block's RTL.
module arp_cache_learn_and_reply_tb;
  import arpc_pkg::*;

  localparam int TableEntries = TABLE_ENTRIES_DEF;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [15:0] OPCODE_REPLY = 16'd2;
  localparam int PhaseWords = 225;
  localparam int PhaseCount = 6;
  localparam int PoolSize = 12;
  localparam int CycleLimit = 500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  arpc_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  arpc_out_t   out_word;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  arpc_in_t  pending_words[$];
  arpc_out_t expected_answers[$];
  int mismatch_count = 0;
  int answers_seen = 0;
  int cycle_count = 0;

  // Behavioral copy of the ARP table and the local address register
  logic        cache_valid [TableEntries];
  logic [31:0] cache_ip [TableEntries];
  logic [47:0] cache_hw [TableEntries];
  logic [31:0] model_local_ip = '0;
  logic [31:0] ip_pool [PoolSize];

  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   hold_left = 0;
  bit   held_once = 1'b0;
  logic stall_next;

  arp_cache_learn_and_reply dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int find_cached(logic [31:0] ip);
    int k;
    for (k = 0; k < TableEntries; k++)
      if (cache_valid[k] && cache_ip[k] == ip) return k;
    return -1;
  endfunction

  // Update the lowest matching entry, else fill the lowest free one, else take entry 0
  function automatic void learn_pair(logic [31:0] ip, logic [47:0] hw);
    int k;
    k = find_cached(ip);
    if (k < 0) begin
      k = 0;
      while (k < TableEntries && cache_valid[k]) k++;
      if (k == TableEntries) k = 0;
      cache_ip[k] = ip;
      cache_valid[k] = 1'b1;
    end
    cache_hw[k] = hw;
  endfunction

  function automatic arpc_out_t predict_arp_answer(arpc_in_t w);
    arpc_out_t a;
    int k;
    a = '0;
    case (w.req_type)
      REQ_LOOKUP: begin
        k = find_cached(w.ip_addr);
        if (k >= 0) begin
          a.hit = 1'b1;
          a.hit_hw_addr = cache_hw[k];
        end
      end
      REQ_ADD: learn_pair(w.ip_addr, w.hw_addr);
      REQ_FRAME: begin
        if (w.frame_len < MIN_FRAME_LEN) begin
          a.frame_dropped = 1'b1;
        end else begin
          learn_pair(w.ip_addr, w.hw_addr);
          if (w.arp_opcode == OPCODE_REQUEST && w.target_addr == model_local_ip) begin
            a.send_reply = 1'b1;
            a.reply_hw_addr = w.hw_addr;
            a.reply_ip = w.ip_addr;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic arpc_in_t make_word(logic [1:0] kind, logic [31:0] ip, logic [47:0] hw,
                                         logic [15:0] op, logic [31:0] tgt, logic [10:0] len);
    arpc_in_t w;
    w.req_type = kind;
    w.ip_addr = ip;
    w.hw_addr = hw;
    w.arp_opcode = op;
    w.target_addr = tgt;
    w.frame_len = len;
    return w;
  endfunction

  // Mostly well-formed requests on a small IP pool so entries hit, update and overflow
  function automatic arpc_in_t random_word();
    arpc_in_t w;
    int roll;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w.ip_addr = ($urandom_range(0, 9) < 7) ? ip_pool[$urandom_range(0, PoolSize - 1)]
                                           : $urandom;
    w.hw_addr = r[47:0];
    w.arp_opcode = r[63:48];
    w.target_addr = $urandom;
    w.frame_len = 11'($urandom_range(0, 2047));
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      w.req_type = REQ_LOOKUP;
    end else if (roll < 55) begin
      w.req_type = REQ_ADD;
    end else if (roll < 95) begin
      w.req_type = REQ_FRAME;
      if ($urandom_range(0, 3) != 0) w.arp_opcode = OPCODE_REQUEST;
      roll = $urandom_range(0, 9);
      if (roll < 7) w.target_addr = model_local_ip;
      else if (roll < 9) w.target_addr = ip_pool[$urandom_range(0, PoolSize - 1)];
      roll = $urandom_range(0, 19);
      if (roll < 3) w.frame_len = 11'($urandom_range(0, MIN_FRAME_LEN - 1));
      else if (roll < 19) w.frame_len = 11'($urandom_range(MIN_FRAME_LEN, 1514));
    end else begin
      w.req_type = REQ_UNKNOWN;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic write_local_ip(logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_local_ip = value;
    @(negedge clk);
  endtask

  // Wait until every queued word is taken and answered, then let the block settle
  task automatic settle_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
    repeat (TableEntries + 4) @(negedge clk);
  endtask

  // Driver: bursts of words with random gaps; predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_answers.push_back(predict_arp_answer(in_word));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes every so often; long hold-offs back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
          if ((!held_once && answers_seen >= 150) || $urandom_range(0, 7) == 0) begin
            held_once = 1'b1;
            hold_left = $urandom_range(200, 400);
          end
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: stall_next = 1'b0;
          1: stall_next = 1'($urandom_range(0, 1));
          2: stall_next = (cycle_count % 5) < 2;
          default: stall_next = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Monitor and run limit
  always @(posedge clk) begin
    arpc_out_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result word", 64'(out_word.hit_hw_addr), '0);
      end else begin
        want = expected_answers.pop_front();
        if (out_word.hit !== want.hit)
          report_mismatch("hit", 64'(out_word.hit), 64'(want.hit));
        if (out_word.hit_hw_addr !== want.hit_hw_addr)
          report_mismatch("hit_hw_addr", 64'(out_word.hit_hw_addr), 64'(want.hit_hw_addr));
        if (out_word.send_reply !== want.send_reply)
          report_mismatch("send_reply", 64'(out_word.send_reply), 64'(want.send_reply));
        if (out_word.reply_hw_addr !== want.reply_hw_addr)
          report_mismatch("reply_hw_addr", 64'(out_word.reply_hw_addr),
                          64'(want.reply_hw_addr));
        if (out_word.reply_ip !== want.reply_ip)
          report_mismatch("reply_ip", 64'(out_word.reply_ip), 64'(want.reply_ip));
        if (out_word.frame_dropped !== want.frame_dropped)
          report_mismatch("frame_dropped", 64'(out_word.frame_dropped),
                          64'(want.frame_dropped));
      end
    end
  end

  initial begin
    int k;
    int phase;
    logic [31:0] local_addr;
    for (k = 0; k < TableEntries; k++) begin
      cache_valid[k] = 1'b0;
      cache_ip[k] = '0;
      cache_hw[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    local_addr = 32'h0A00_0001;
    write_local_ip(local_addr);
    // Empty table, short frames, reply on exact minimum length
    pending_words.push_back(make_word(REQ_LOOKUP, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0002, 48'h0200_0000_00A1,
                                      OPCODE_REQUEST, local_addr, '0));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0002, 48'h0200_0000_00A1,
                                      OPCODE_REQUEST, local_addr, MIN_FRAME_LEN - 11'd1));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0002, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0002, 48'h0200_0000_00A1,
                                      OPCODE_REQUEST, local_addr, MIN_FRAME_LEN));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0002, '1, '1, '1, '1));
    // Field extremes in the table
    pending_words.push_back(make_word(REQ_ADD, '0, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_ADD, '1, '1, '1, '1, '1));
    pending_words.push_back(make_word(REQ_LOOKUP, '1, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_LOOKUP, '0, '1, '1, '1, '1));
    // Update of an existing pair
    pending_words.push_back(make_word(REQ_ADD, 32'hC0A8_0002, 48'hFEED_0000_BEEF, '0, '0, '0));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0002, '0, '0, '0, '0));
    // Frames that learn but ask for no reply, then an unknown request type
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0003, 48'h0200_0000_00B2,
                                      OPCODE_REPLY, local_addr, '1));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0004, 48'h0200_0000_00C3,
                                      OPCODE_REQUEST, ~local_addr, 11'd60));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0005, 48'h0200_0000_00D4,
                                      '1, local_addr, 11'd60));
    pending_words.push_back(make_word(REQ_UNKNOWN, '1, '1, '1, '1, '1));
    // Fill the table, then overflow into entry 0
    pending_words.push_back(make_word(REQ_ADD, 32'hC0A8_0006, 48'h0200_0000_00E5, '0, '0, '0));
    pending_words.push_back(make_word(REQ_ADD, 32'hC0A8_0007, 48'h0200_0000_00F6, '0, '0, '0));
    pending_words.push_back(make_word(REQ_FRAME, 32'hC0A8_0008, 48'h0200_0000_0107,
                                      OPCODE_REQUEST, local_addr, 11'd64));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0002, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0008, '0, '0, '0, '0));
    pending_words.push_back(make_word(REQ_LOOKUP, 32'hC0A8_0007, '0, '0, '0, '0));
    settle_idle();

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: local_addr = '0;
        1: local_addr = '1;
        default: local_addr = $urandom;
      endcase
      write_local_ip(local_addr);
      // More pool addresses than entries, so the table overflows regularly
      ip_pool[0] = local_addr;
      ip_pool[1] = (phase % 2 == 0) ? '0 : '1;
      for (k = 2; k < PoolSize; k++) ip_pool[k] = $urandom;
      repeat (PhaseWords) pending_words.push_back(random_word());
      settle_idle();
    end

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* arp_cache_learn_and_reply.f */
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_cell.sv
sv/arp_cache_learn_and_reply.sv
sim/arp_cache_learn_and_reply_tb.sv
